### rtl/core/lsc_pkg.sv
// Package for the sheet cache directory: sizes, outcome codes and the result record.
package lsc_pkg;

   localparam int ENTRIES = 4;
   localparam int TOP     = ENTRIES - 1;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int KEY_W   = 8;
   localparam int POS_W   = 2;

   typedef enum logic [1:0] {
      OUTCOME_HIT    = 2'd0,
      OUTCOME_INSERT = 2'd1,
      OUTCOME_FAIL   = 2'd2
   } outcome_type;

   typedef struct packed {
      outcome_type        outcome;
      logic [POS_W-1:0]   hit_position;
      logic               evict_valid;
      logic [KEY_W-1:0]   evict_tile_size;
      logic [KEY_W-1:0]   evict_sheet_number;
   } result_type;

endpackage

### rtl/core/lsc_dir.sv
// Cache directory: slot registers in recency order, key match and LRU reorder.
module lsc_dir (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       lookup_en,
   input  logic [lsc_pkg::KEY_W-1:0]  tile_size,
   input  logic [lsc_pkg::KEY_W-1:0]  sheet_number,
   input  logic                       load_ok,
   output lsc_pkg::result_type        result
);
   import lsc_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [KEY_W-1:0]   tile_ff  [ENTRIES];
   logic [KEY_W-1:0]   tile_in  [ENTRIES];
   logic [KEY_W-1:0]   sheet_ff [ENTRIES];
   logic [KEY_W-1:0]   sheet_in [ENTRIES];

   logic [ENTRIES-1:0] match;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   shift_from;
   logic               hit;
   logic               update;

   // Lowest matching slot wins; scan from the top so the oldest match is kept.
   always_comb begin
      match   = '0;
      hit_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tile_ff[i] == tile_size) && (sheet_ff[i] == sheet_number);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit        = |match;
   assign update     = lookup_en && (hit || load_ok);
   assign shift_from = hit ? hit_idx : '0;

   // Slots at or above shift_from move down one; the top slot takes the key.
   always_comb begin
      for (int j = 0; j < TOP; j++) begin
         if (update && (IDX_W'(j) >= shift_from)) begin
            valid_in[j] = valid_ff[j+1];
            tile_in[j]  = tile_ff[j+1];
            sheet_in[j] = sheet_ff[j+1];
         end else begin
            valid_in[j] = valid_ff[j];
            tile_in[j]  = tile_ff[j];
            sheet_in[j] = sheet_ff[j];
         end
      end
      if (update) begin
         valid_in[TOP] = 1'b1;
         tile_in[TOP]  = tile_size;
         sheet_in[TOP] = sheet_number;
      end else begin
         valid_in[TOP] = valid_ff[TOP];
         tile_in[TOP]  = tile_ff[TOP];
         sheet_in[TOP] = sheet_ff[TOP];
      end
   end

   always_comb begin
      result.outcome            = hit ? OUTCOME_HIT : (load_ok ? OUTCOME_INSERT : OUTCOME_FAIL);
      result.hit_position       = hit ? POS_W'(hit_idx) : '0;
      result.evict_valid        = !hit && load_ok && valid_ff[0];
      result.evict_tile_size    = result.evict_valid ? tile_ff[0] : '0;
      result.evict_sheet_number = result.evict_valid ? sheet_ff[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Keys are only observed through valid slots.
   always_ff @(posedge clock) begin
      for (int j = 0; j < ENTRIES; j++) begin
         tile_ff[j]  <= tile_in[j];
         sheet_ff[j] <= sheet_in[j];
      end
   end

`ifndef NO_ASSERTIONS
   // Keys in the directory are unique, so a lookup matches at most one slot.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      lookup_en |-> $onehot0(match))
      else $error("lsc_dir: key present in more than one slot");

   // Valid slots always form a run ending at the most recent slot.
   a_valid_suffix: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[TOP-1:0] & ~valid_ff[TOP:1]) == '0)
      else $error("lsc_dir: hole in valid slots");

   a_top_filled: assert property (@(posedge clock) disable iff (reset)
      update |=> valid_ff[TOP])
      else $error("lsc_dir: most recent slot empty after update");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (lookup_en && !hit && !load_ok) |=> $stable(valid_ff))
      else $error("lsc_dir: failed load changed the directory");
`endif

endmodule

### rtl/core/lru_sheet_cache.sv
// Top level: request register, cache directory and response register.
// A request waits in the request register, then moves into the response register.
// One request per cycle while results are taken; match and reorder are combinational.
// The request register can take one new request while a result waits to be taken.
// Reset (synchronous, active high) empties both registers and invalidates all slots.
module lru_sheet_cache (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lsc_pkg::KEY_W-1:0]  req_tile_size,
   input  logic [lsc_pkg::KEY_W-1:0]  req_sheet_number,
   input  logic                       req_load_ok,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_outcome,
   output logic [lsc_pkg::POS_W-1:0]  rsp_hit_position,
   output logic                       rsp_evict_valid,
   output logic [lsc_pkg::KEY_W-1:0]  rsp_evict_tile_size,
   output logic [lsc_pkg::KEY_W-1:0]  rsp_evict_sheet_number
);
   import lsc_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [KEY_W-1:0]  in_tile_ff;
   logic [KEY_W-1:0]  in_sheet_ff;
   logic              in_load_ok_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   result_type        dir_result;
   logic              advance;
   logic              req_xfer;

   // The held request is looked up in the cycle it moves into the response register.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   lsc_dir u_dir (
      .clock        (clock),
      .reset        (reset),
      .lookup_en    (advance),
      .tile_size    (in_tile_ff),
      .sheet_number (in_sheet_ff),
      .load_ok      (in_load_ok_ff),
      .result       (dir_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_tile_ff    <= req_tile_size;
         in_sheet_ff   <= req_sheet_number;
         in_load_ok_ff <= req_load_ok;
      end
      if (advance) begin
         rsp_ff <= dir_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_outcome            = rsp_ff.outcome;
   assign rsp_hit_position       = rsp_ff.hit_position;
   assign rsp_evict_valid        = rsp_ff.evict_valid;
   assign rsp_evict_tile_size    = rsp_ff.evict_tile_size;
   assign rsp_evict_sheet_number = rsp_ff.evict_sheet_number;

endmodule

### bench/lru_sheet_cache_test.sv
// Self-checking bench for lru_sheet_cache: LRU directory predictor with random bursts and stalls.
`timescale 1ns / 100ps

module lru_sheet_cache_test;

   localparam int RANDOM_LOOKUPS = 1130;
   localparam int POOL_KEYS      = 6;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct packed {
      logic [lsc_pkg::KEY_W-1:0] tile_size;
      logic [lsc_pkg::KEY_W-1:0] sheet_number;
      logic                      load_ok;
   } sheet_lookup_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [lsc_pkg::KEY_W-1:0]   req_tile_size = '0;
   logic [lsc_pkg::KEY_W-1:0]   req_sheet_number = '0;
   logic                        req_load_ok = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_outcome;
   logic [lsc_pkg::POS_W-1:0]   rsp_hit_position;
   logic                        rsp_evict_valid;
   logic [lsc_pkg::KEY_W-1:0]   rsp_evict_tile_size;
   logic [lsc_pkg::KEY_W-1:0]   rsp_evict_sheet_number;

   sheet_lookup_type     pending_lookups[$];
   lsc_pkg::result_type  expected_results[$];
   int                   error_count = 0;

   // predictor copy of the directory, slot 0 is least recently used
   logic                      dir_live[lsc_pkg::ENTRIES] = '{default: 1'b0};
   logic [lsc_pkg::KEY_W-1:0] dir_tile[lsc_pkg::ENTRIES] = '{default: '0};
   logic [lsc_pkg::KEY_W-1:0] dir_sheet[lsc_pkg::ENTRIES] = '{default: '0};

   int burst_left = 0;
   int gap_left   = 0;
   int rsp_count  = 0;
   int hold_left  = 0;
   bit held_once  = 1'b0;
   int mode_left  = 0;
   int stall_mode = 0;
   int cycle_cnt  = 0;

   always #4 clock = ~clock;

   lru_sheet_cache u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_tile_size          (req_tile_size),
      .req_sheet_number       (req_sheet_number),
      .req_load_ok            (req_load_ok),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_outcome            (rsp_outcome),
      .rsp_hit_position       (rsp_hit_position),
      .rsp_evict_valid        (rsp_evict_valid),
      .rsp_evict_tile_size    (rsp_evict_tile_size),
      .rsp_evict_sheet_number (rsp_evict_sheet_number)
   );

   // Moves entries from..TOP down one slot and puts the key at the MRU end.
   function automatic void promote_key(int from, sheet_lookup_type lk);
      for (int j = from; j < lsc_pkg::TOP; j++) begin
         dir_live[j]  = dir_live[j+1];
         dir_tile[j]  = dir_tile[j+1];
         dir_sheet[j] = dir_sheet[j+1];
      end
      dir_live[lsc_pkg::TOP]  = 1'b1;
      dir_tile[lsc_pkg::TOP]  = lk.tile_size;
      dir_sheet[lsc_pkg::TOP] = lk.sheet_number;
   endfunction

   function automatic lsc_pkg::result_type lookup_sheet(sheet_lookup_type lk);
      lsc_pkg::result_type res;
      int                  hit_slot;
      res      = '0;
      hit_slot = -1;
      for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
         if (hit_slot < 0 && dir_live[i] && dir_tile[i] == lk.tile_size
             && dir_sheet[i] == lk.sheet_number)
            hit_slot = i;
      end
      if (hit_slot >= 0) begin
         res.outcome      = lsc_pkg::OUTCOME_HIT;
         res.hit_position = hit_slot[lsc_pkg::POS_W-1:0];
         promote_key(hit_slot, lk);
      end else if (!lk.load_ok) begin
         res.outcome = lsc_pkg::OUTCOME_FAIL;
      end else begin
         res.outcome = lsc_pkg::OUTCOME_INSERT;
         if (dir_live[0]) begin
            res.evict_valid        = 1'b1;
            res.evict_tile_size    = dir_tile[0];
            res.evict_sheet_number = dir_sheet[0];
         end
         promote_key(0, lk);
      end
      return res;
   endfunction

   task automatic queue_lookup(input logic [7:0] ts, input logic [7:0] sn, input logic ok);
      sheet_lookup_type lk;
      lk.tile_size    = ts;
      lk.sheet_number = sn;
      lk.load_ok      = ok;
      pending_lookups.push_back(lk);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(lookup_sheet(pending_lookups.pop_front()));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_lookups.size() != 0) begin
               req_valid        <= 1'b1;
               req_tile_size    <= pending_lookups[0].tile_size;
               req_sheet_number <= pending_lookups[0].sheet_number;
               req_load_ok      <= pending_lookups[0].load_ok;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: switches between stall patterns, plus one long hold-off
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!held_once && rsp_count >= HOLD_AT) begin
         held_once <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= cycle_cnt[0];
            2: rsp_ready <= ($urandom_range(0, 2) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transfer, outcome %0d", $time, rsp_outcome);
            error_count++;
         end else begin
            lsc_pkg::result_type want;
            want = expected_results.pop_front();
            check_field("outcome", 8'(want.outcome), 8'(rsp_outcome));
            check_field("hit_position", 8'(want.hit_position), 8'(rsp_hit_position));
            check_field("evict_valid", 8'(want.evict_valid), 8'(rsp_evict_valid));
            check_field("evict_tile_size", want.evict_tile_size, rsp_evict_tile_size);
            check_field("evict_sheet_number", want.evict_sheet_number,
                        rsp_evict_sheet_number);
         end
      end
   end

   initial begin
      sheet_lookup_type key_pool[POOL_KEYS];
      int               pick;
      int               slot;
      logic [7:0]       ts;
      logic [7:0]       sn;

      // invalid slot holding key 0/0 must not hit
      queue_lookup(8'd0,   8'd0,   1'b0);
      queue_lookup(8'd0,   8'd0,   1'b1);   // evicts an empty slot
      queue_lookup(8'd255, 8'd255, 1'b1);
      queue_lookup(8'd255, 8'd0,   1'b1);
      queue_lookup(8'd0,   8'd255, 1'b1);   // directory now full
      queue_lookup(8'd0,   8'd0,   1'b1);   // hit, oldest slot
      queue_lookup(8'd255, 8'd0,   1'b0);   // hit with failing load
      queue_lookup(8'd0,   8'd255, 1'b1);   // hit, middle slot
      queue_lookup(8'd255, 8'd0,   1'b1);   // hit, second newest slot
      queue_lookup(8'd1,   8'd2,   1'b0);   // miss, load failed
      queue_lookup(8'd1,   8'd2,   1'b1);   // evicts a valid entry
      queue_lookup(8'd1,   8'd3,   1'b1);   // same tile size, other sheet
      queue_lookup(8'd2,   8'd2,   1'b1);   // same sheet, other tile size
      queue_lookup(8'd170, 8'd85,  1'b1);
      queue_lookup(8'd85,  8'd170, 1'b1);
      queue_lookup(8'd128, 8'd127, 1'b1);
      queue_lookup(8'd127, 8'd128, 1'b0);
      queue_lookup(8'd170, 8'd85,  1'b0);
      queue_lookup(8'd128, 8'd127, 1'b1);
      queue_lookup(8'd85,  8'd170, 1'b1);

      // small pool of keys, a bit larger than the directory, mixes hits and evictions
      for (int k = 0; k < POOL_KEYS; k++)
         key_pool[k] = {8'($urandom), 8'($urandom), 1'b1};
      for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, POOL_KEYS - 1);
         if (pick < 10) begin
            ts = (pick < 5) ? key_pool[slot].tile_size : 8'($urandom);
            queue_lookup(ts, 8'($urandom), 1'($urandom));
         end else begin
            if (pick < 16) begin
               key_pool[slot].tile_size    = 8'($urandom);
               key_pool[slot].sheet_number = 8'($urandom);
            end
            queue_lookup(key_pool[slot].tile_size, key_pool[slot].sheet_number,
                         $urandom_range(0, 4) != 0);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_lookups.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### lru_sheet_cache.f
rtl/core/lsc_pkg.sv
rtl/core/lsc_dir.sv
rtl/core/lru_sheet_cache.sv
bench/lru_sheet_cache_test.sv
